[sv/aob_pkg.sv]
`timescale 1ns / 1ps

package aob_pkg;

   localparam int unsigned PIX_W = 32;
   localparam int unsigned CH_W = 8;
   localparam int unsigned NUM_COLOURS = 3;
   localparam int unsigned PROD_W = 2 * CH_W;
   localparam int unsigned COL_X_W = 3 * CH_W;
   localparam int unsigned NUM_W = PROD_W + 1;

   localparam logic [CH_W-1:0] BLEND_FULL = 8'd255;
   localparam logic [CH_W-1:0] BLEND_HALF = 8'd127;

   // x / 255 == (x * 8421505) >> 31, exact for every x below 16.9 million
   localparam int unsigned RECIP_W = 24;
   localparam logic [RECIP_W-1:0] RECIP_255 = 24'd8421505;
   localparam int unsigned RECIP_SHIFT = 31;
   localparam int unsigned RECIP_PROD_W = 2 * RECIP_W;

   // restoring divider, quotient bits retired per pipeline stage
   localparam int unsigned DIV_STEPS = 4;
   localparam int unsigned DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int unsigned DIV_LAST_STEPS = NUM_W - DIV_STEPS * (DIV_STAGES - 1);

   // front, two scaling stages, numerator, divider, output register
   localparam int unsigned LATENCY = 4 + DIV_STAGES + 1;

   typedef struct packed {
      logic                                 valid;
      logic [CH_W-1:0]                      sa;
      logic [CH_W-1:0]                      inv;
      logic [PROD_W-1:0]                    ax;
      logic [NUM_COLOURS-1:0][PROD_W-1:0]   cd;
      logic [NUM_COLOURS-1:0][PROD_W-1:0]   cs;
   } front_type;

   typedef struct packed {
      logic [CH_W-1:0]  rem;
      logic [NUM_W-1:0] dvd;
      logic [NUM_W-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic                                valid;
      logic [CH_W-1:0]                     alpha;
      logic [NUM_COLOURS-1:0]              unused_pad;
      div_lane_type [NUM_COLOURS-1:0]      lane;
   } div_beat_type;

   function automatic logic [NUM_W-1:0] div255(input logic [COL_X_W-1:0] x);
      logic [RECIP_PROD_W-1:0] p;
      p = RECIP_PROD_W'(x) * RECIP_PROD_W'(RECIP_255);
      return p[RECIP_SHIFT +: NUM_W];
   endfunction

endpackage

[sv/aob_front.sv]
`timescale 1ns / 1ps

module aob_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [aob_pkg::PIX_W-1:0]    src_pixel,
   input  logic [aob_pkg::PIX_W-1:0]    dst_pixel,
   output aob_pkg::front_type           front
);
   import aob_pkg::*;

   front_type data_in;
   front_type data_ff;

   always_comb begin
      logic [CH_W-1:0] sa;
      logic [CH_W-1:0] da;
      logic [CH_W-1:0] inv;
      sa = src_pixel[3*CH_W +: CH_W];
      da = dst_pixel[3*CH_W +: CH_W];
      inv = BLEND_FULL - sa;
      data_in.valid = accept;
      data_in.sa = sa;
      data_in.inv = inv;
      data_in.ax = PROD_W'(da) * PROD_W'(inv) + PROD_W'(BLEND_HALF);
      for (int c = 0; c < NUM_COLOURS; c++) begin
         data_in.cd[c] = PROD_W'(dst_pixel[c*CH_W +: CH_W]) * PROD_W'(da);
         data_in.cs[c] = PROD_W'(src_pixel[c*CH_W +: CH_W]) * PROD_W'(sa);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
      data_ff.sa <= data_in.sa;
      data_ff.inv <= data_in.inv;
      data_ff.ax <= data_in.ax;
      data_ff.cd <= data_in.cd;
      data_ff.cs <= data_in.cs;
   end

   assign front = data_ff;

endmodule

[sv/aob_scale.sv]
`timescale 1ns / 1ps

module aob_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  aob_pkg::front_type    front,
   output aob_pkg::div_beat_type beat
);
   import aob_pkg::*;

   // stage 2: reciprocal product for alpha, destination colour weighting
   logic                                 v2_in, v2_ff;
   logic [CH_W-1:0]                      sa2_ff;
   logic [CH_W-1:0]                      aq2_in, aq2_ff;
   logic [NUM_COLOURS-1:0][COL_X_W-1:0]  cx2_in, cx2_ff;
   logic [NUM_COLOURS-1:0][PROD_W-1:0]   cs2_ff;
   // stage 3: output alpha and reciprocal products for colours
   logic                                 v3_ff;
   logic [CH_W-1:0]                      oa3_in, oa3_ff;
   logic [NUM_COLOURS-1:0][PROD_W-1:0]   cq3_in, cq3_ff;
   logic [NUM_COLOURS-1:0][PROD_W-1:0]   cs3_ff;
   // stage 4: numerators
   div_beat_type                         beat_in, beat_ff;

   always_comb begin
      logic [NUM_W-1:0] q;
      v2_in = front.valid;
      q = div255(COL_X_W'(front.ax));
      aq2_in = q[CH_W-1:0];
      for (int c = 0; c < NUM_COLOURS; c++) begin
         cx2_in[c] = COL_X_W'(front.cd[c]) * COL_X_W'(front.inv)
                   + COL_X_W'(BLEND_HALF);
      end
   end

   always_comb begin
      logic [NUM_W-1:0] q;
      oa3_in = sa2_ff + aq2_ff;
      for (int c = 0; c < NUM_COLOURS; c++) begin
         q = div255(cx2_ff[c]);
         cq3_in[c] = q[PROD_W-1:0];
      end
   end

   always_comb begin
      beat_in.valid = v3_ff;
      beat_in.alpha = oa3_ff;
      beat_in.unused_pad = '0;
      for (int c = 0; c < NUM_COLOURS; c++) begin
         beat_in.lane[c].rem = '0;
         beat_in.lane[c].quo = '0;
         beat_in.lane[c].dvd = NUM_W'(cs3_ff[c]) + NUM_W'(cq3_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         beat_ff.valid <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v2_ff;
         beat_ff.valid <= beat_in.valid;
      end
      sa2_ff <= front.sa;
      aq2_ff <= aq2_in;
      cx2_ff <= cx2_in;
      cs2_ff <= front.cs;
      oa3_ff <= oa3_in;
      cq3_ff <= cq3_in;
      cs3_ff <= cs2_ff;
      beat_ff.alpha <= beat_in.alpha;
      beat_ff.unused_pad <= beat_in.unused_pad;
      beat_ff.lane <= beat_in.lane;
   end

   assign beat = beat_ff;

endmodule

[sv/aob_div_stage.sv]
`timescale 1ns / 1ps

module aob_div_stage #(
   parameter int unsigned STEPS = aob_pkg::DIV_STEPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  aob_pkg::div_beat_type up_beat,
   output aob_pkg::div_beat_type dn_beat
);
   import aob_pkg::*;

   div_beat_type beat_in;
   div_beat_type beat_ff;

   always_comb begin
      logic [CH_W:0] trial;
      logic [CH_W:0] diff;
      beat_in = up_beat;
      for (int c = 0; c < NUM_COLOURS; c++) begin
         for (int s = 0; s < STEPS; s++) begin
            trial = {beat_in.lane[c].rem, beat_in.lane[c].dvd[NUM_W-1]};
            diff = trial - {1'b0, beat_in.alpha};
            beat_in.lane[c].dvd = {beat_in.lane[c].dvd[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, beat_in.alpha}) begin
               beat_in.lane[c].rem = diff[CH_W-1:0];
               beat_in.lane[c].quo = {beat_in.lane[c].quo[NUM_W-2:0], 1'b1};
            end else begin
               beat_in.lane[c].rem = trial[CH_W-1:0];
               beat_in.lane[c].quo = {beat_in.lane[c].quo[NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.alpha <= beat_in.alpha;
      beat_ff.unused_pad <= beat_in.unused_pad;
      beat_ff.lane <= beat_in.lane;
   end

   assign dn_beat = beat_ff;

endmodule

[sv/alpha_over_blend_rgba8_unit.sv]
`timescale 1ns / 1ps
// a beat taken at one clock edge passes the front, scaling, divider and output registers
// before it shows on rsp_* and is taken by the receiver (depth in aob_pkg::LATENCY)
// throughput: one pixel per clock, set by the fully pipelined multipliers and divider stages
// the receiver cannot stall, so a result is presented for exactly one cycle with rsp_valid
// reset clears every valid bit in the pipeline; busy is high only while reset is held
// payload registers are not reset and carry no meaning while their valid bit is low

module alpha_over_blend_rgba8_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [aob_pkg::PIX_W-1:0]   req_src_pixel,
   input  logic [aob_pkg::PIX_W-1:0]   req_dst_pixel,
   output logic                        rsp_valid,
   output logic [aob_pkg::PIX_W-1:0]   rsp_out_pixel
);
   import aob_pkg::*;

   logic          accept;
   front_type     front;
   div_beat_type  chain [DIV_STAGES+1];

   logic                rsp_valid_in, rsp_valid_ff;
   logic [PIX_W-1:0]    rsp_pixel_in, rsp_pixel_ff;

   // the pipeline never holds off; only reset blocks new beats
   assign busy = reset;
   assign accept = start & ~busy;

   // stage 1: byte unpacking, inverse alpha and all 8x8 products
   aob_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .src_pixel (req_src_pixel),
      .dst_pixel (req_dst_pixel),
      .front     (front)
   );

   // stages 2 to 4: rounded divisions by 255 through reciprocal products,
   // then output alpha and the three colour numerators
   aob_scale u_scale (
      .clock (clock),
      .reset (reset),
      .front (front),
      .beat  (chain[0])
   );

   // restoring divider, numerator / output alpha, a few quotient bits per stage;
   // the last stage takes whatever bits are left over
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      localparam int unsigned STEPS = (g == DIV_STAGES - 1) ? DIV_LAST_STEPS : DIV_STEPS;
      aob_div_stage #(
         .STEPS (STEPS)
      ) u_div_stage (
         .clock   (clock),
         .reset   (reset),
         .up_beat (chain[g]),
         .dn_beat (chain[g+1])
      );
   end

   // output register: zero alpha forces the whole pixel to zero,
   // colour quotients keep only their low byte (wrap past 255)
   always_comb begin
      rsp_valid_in = chain[DIV_STAGES].valid;
      if (chain[DIV_STAGES].alpha == '0) begin
         rsp_pixel_in = '0;
      end else begin
         rsp_pixel_in = {chain[DIV_STAGES].alpha,
                         chain[DIV_STAGES].lane[2].quo[CH_W-1:0],
                         chain[DIV_STAGES].lane[1].quo[CH_W-1:0],
                         chain[DIV_STAGES].lane[0].quo[CH_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;

   // every result goes back to a beat taken exactly one latency earlier
   a_result_has_source : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without a matching input beat");

   // a transparent result must be all zeros
   a_zero_alpha_clears : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_pixel[PIX_W-1 -: CH_W] == '0) |-> (rsp_out_pixel == '0))
      else $error("zero alpha with non-zero colour");

   // composited alpha never falls below the source alpha
   a_alpha_not_below_src : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_pixel[PIX_W-1 -: CH_W] >=
                     $past(req_src_pixel[PIX_W-1 -: CH_W], LATENCY)))
      else $error("output alpha below source alpha");

endmodule

[dv/tb_alpha_over_blend_rgba8_unit.sv]
`timescale 1ns / 1ps

module tb_alpha_over_blend_rgba8_unit;

   import aob_pkg::*;

   // one accepted beat and the pixel it must produce
   typedef struct {
      logic [PIX_W-1:0] src;
      logic [PIX_W-1:0] dst;
      logic [PIX_W-1:0] pixel;
   } blend_beat_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [PIX_W-1:0] req_src_pixel = '0;
   logic [PIX_W-1:0] req_dst_pixel = '0;
   logic             rsp_valid;
   logic [PIX_W-1:0] rsp_out_pixel;

   blend_beat_type   pending_blends[$];
   int unsigned      mismatch_count = 0;

   alpha_over_blend_rgba8_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_src_pixel (req_src_pixel),
      .req_dst_pixel (req_dst_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_out_pixel (rsp_out_pixel)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop in case a beat is lost or the block locks up
   initial begin
      #2_000_000;
      $display("tb_alpha_over_blend_rgba8_unit: done, errors");
      $finish;
   end

   // source-over composite of one straight-alpha pixel
   // alpha is sa plus the rounded destination share; a zero alpha blanks the pixel
   // each colour quotient keeps only its low byte, so rounding overshoot wraps
   function automatic logic [PIX_W-1:0] composite_over(input logic [PIX_W-1:0] src,
                                                       input logic [PIX_W-1:0] dst);
      int unsigned      sa;
      int unsigned      da;
      int unsigned      inv;
      int unsigned      oa;
      int unsigned      num;
      int               c;
      logic [PIX_W-1:0] px;
      sa  = src[31:24];
      da  = dst[31:24];
      inv = BLEND_FULL - sa;
      oa  = (sa + (da * inv + BLEND_HALF) / BLEND_FULL) & 32'hFF;
      px  = '0;
      if (oa != 0) begin
         for (c = 0; c < NUM_COLOURS; c++) begin
            num = src[CH_W*c +: CH_W] * sa
                + (dst[CH_W*c +: CH_W] * da * inv + BLEND_HALF) / BLEND_FULL;
            px[CH_W*c +: CH_W] = CH_W'(num / oa);
         end
         px[31:24] = oa[7:0];
      end
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // called just after a rising edge; returns at the edge that takes the beat
   // start is left high so a following beat can go straight out
   task automatic send_pixel(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
      blend_beat_type b;
      start         <= 1'b1;
      req_src_pixel <= src;
      req_dst_pixel <= dst;
      @(posedge clock);
      while (busy) @(posedge clock);
      b.src   = src;
      b.dst   = dst;
      b.pixel = composite_over(src, dst);
      pending_blends.push_back(b);
   endtask

   // alpha leans towards the extremes and tiny values, where rounding bites hardest
   function automatic logic [PIX_W-1:0] random_pixel();
      logic [7:0]  alpha;
      logic [23:0] colours;
      case ($urandom_range(0, 5))
         0: alpha = 8'h00;
         1: alpha = 8'hFF;
         2: alpha = 8'($urandom_range(1, 8));
         3: alpha = 8'($urandom_range(247, 254));
         default: alpha = 8'($urandom);
      endcase
      // saturated colours make the wrapping quotient reachable
      colours = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom);
      return {alpha, colours};
   endfunction

   // idle_pct: chance per cycle that the sender holds start low
   task automatic random_burst(input int unsigned count, input int unsigned idle_pct);
      int unsigned n;
      for (n = 0; n < count; n++) begin
         while ($urandom_range(0, 99) < idle_pct) begin
            start         <= 1'b0;
            req_src_pixel <= $urandom;
            req_dst_pixel <= $urandom;
            @(posedge clock);
         end
         send_pixel(random_pixel(), random_pixel());
      end
   endtask

   task automatic test_corner_pixels();
      // both alphas zero: whole pixel blanks, colours ignored
      send_pixel(32'h0000_0000, 32'h0000_0000);
      send_pixel(32'h0012_3456, 32'h00AB_CDEF);
      // all ones, opaque source over anything
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(32'hFF00_0000, 32'hFFFF_FFFF);
      // transparent source: destination shows through; last, faint source over transparent destination
      send_pixel(32'h00FF_FFFF, 32'hFF00_0000);
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(32'h00FF_FFFF, 32'h01FF_FFFF);
      send_pixel(32'h0100_FF00, 32'h00FF_00FF);
      // roughly half and half, then a near-opaque source over a faint destination
      send_pixel(32'h80FF_0000, 32'h8000_00FF);
      send_pixel(32'h7F80_8080, 32'hFF7F_7F7F);
      send_pixel(32'hFE01_0203, 32'h01FD_FEFF);
      // destination share rounds down; in the first two the colour quotient passes 255 and wraps
      send_pixel(32'h02FF_FFFF, 32'h40FF_FFFF);
      send_pixel(32'h04FF_FFFF, 32'h20FF_FFFF);
      send_pixel(32'h01FF_FFFF, 32'h80FF_FFFF);
      // alternating bit patterns on every lane
      send_pixel(32'h55AA_55AA, 32'hAA55_AA55);
      send_pixel(32'hAA55_AA55, 32'h55AA_55AA);
   endtask

   task automatic test_back_to_back();
      random_burst(400, 0);
   endtask

   task automatic test_sparse_sender();
      random_burst(400, 87);
   endtask

   task automatic test_light_gaps();
      random_burst(400, 9);
   endtask

   // results cannot be held off, so every strobe is checked on the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_blends.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing outstanding", rsp_out_pixel));
         end else begin
            if (rsp_out_pixel !== pending_blends[0].pixel)
               report_mismatch($sformatf("src %h dst %h: out_pixel %h, wanted %h",
                                         pending_blends[0].src, pending_blends[0].dst,
                                         rsp_out_pixel, pending_blends[0].pixel));
            void'(pending_blends.pop_front());
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_corner_pixels();
      test_back_to_back();
      test_sparse_sender();
      test_light_gaps();
      start <= 1'b0;

      // drain, then watch a little longer for stray strobes
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_alpha_over_blend_rgba8_unit: done, clean");
      end else begin
         $display("tb_alpha_over_blend_rgba8_unit: done, errors");
      end
      $finish;
   end

endmodule
